[rtl/fsf_pkg.sv]
// Shared types and constants of the frame store drawing engine.
package fsf_pkg;

  localparam int ROWS_DEF     = 128;
  localparam int BPR_DEF      = 32;
  localparam int PIX_PER_BYTE = 4;
  localparam int FIELD_W      = 10;
  localparam int RAD_W        = 9;
  localparam int SQ_W         = 2 * RAD_W;
  localparam int COORD_W      = 13;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_FILL   = 3'd1,
    MODE_HOLLOW = 3'd2,
    MODE_DISC   = 3'd3,
    MODE_RING   = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    K_CLEAR, K_FILL, K_HOLLOW, K_DISC, K_RING, K_READ, K_NOP
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_W-1:0]    x;
    logic [FIELD_W-1:0]    y;
    logic [FIELD_W-1:0]    w;
    logic [FIELD_W-1:0]    h;
    logic [RAD_W-1:0]      r;
    logic [FIELD_W-1:0]    t;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RECT, S_RECT_ROW, S_DISC_ROW, S_DISC_MUL, S_DISC_SQ,
    S_DISC_WAIT, S_DISC_NEXT, S_SPAN_START, S_SPAN_RD, S_SPAN_WR, S_READ,
    S_READ_WAIT, S_DONE
  } state_t;

endpackage

[rtl/framebuffer_shape_fill.sv]
// Top level of the monochrome frame store drawing engine.
//
// Commands arrive on the cmd channel (cmd_valid/cmd_ready), one word per
// command; results leave on the res channel (res_valid/res_ready), one word
// per command, in order. A two-entry command queue lets the host post the
// next command while the sequencer is drawing or a result waits.
// Each command runs alone in the sequencer; its length is set by the
// single-port store, each byte of a span being read and then written:
//   clear:     every byte of the store is written to zero;
//   rectangle: a set-up step per band, a row step per row, then its span;
//   disc:      per row a row test, the squares, the serial square root
//              and the span, over 2r+1 rows, and a ring whose thickness
//              is below the radius adds a second pass for the inner disc;
//   read:      one store read.
// After reset the store is swept to zero, one byte a cycle; commands
// queue meanwhile but do not start.
// When the receiver stalls the result is held in its output register and
// the sequencer waits at its end of command, while the queue fills.
module framebuffer_shape_fill #(
  parameter int ROWS          = fsf_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = fsf_pkg::BPR_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [2:0]                   mode,
  input  logic [fsf_pkg::FIELD_W-1:0]  pos_x,
  input  logic [fsf_pkg::FIELD_W-1:0]  pos_y,
  input  logic [fsf_pkg::FIELD_W-1:0]  rect_width,
  input  logic [fsf_pkg::FIELD_W-1:0]  rect_height,
  input  logic [fsf_pkg::RAD_W-1:0]    radius,
  input  logic [fsf_pkg::FIELD_W-1:0]  thickness,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [7:0]                   read_data,
  output logic                         done_res
);

  logic          q_valid;
  logic          q_pop;
  fsf_pkg::cmd_t q_cmd;

  fsf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .mode        (mode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .radius      (radius),
    .thickness   (thickness),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop)
  );

  fsf_back #(
    .ROWS          (ROWS),
    .BYTES_PER_ROW (BYTES_PER_ROW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .read_data (read_data),
    .done_res  (done_res)
  );

endmodule

[rtl/fsf_front.sv]
// Command front end: decodes the mode and holds words in a two-entry queue.
module fsf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  logic [2:0]                   mode,
  input  logic [fsf_pkg::FIELD_W-1:0]  pos_x,
  input  logic [fsf_pkg::FIELD_W-1:0]  pos_y,
  input  logic [fsf_pkg::FIELD_W-1:0]  rect_width,
  input  logic [fsf_pkg::FIELD_W-1:0]  rect_height,
  input  logic [fsf_pkg::RAD_W-1:0]    radius,
  input  logic [fsf_pkg::FIELD_W-1:0]  thickness,
  output logic                         q_valid,
  output fsf_pkg::cmd_t                q_cmd,
  input  logic                         q_pop
);

  fsf_pkg::cmd_t q_mem [2];
  fsf_pkg::cmd_t in_cmd;
  fsf_pkg::kind_t in_kind;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;

  always_comb begin
    case (mode)
      fsf_pkg::MODE_CLEAR:  in_kind = fsf_pkg::K_CLEAR;
      fsf_pkg::MODE_FILL:   in_kind = fsf_pkg::K_FILL;
      fsf_pkg::MODE_HOLLOW: in_kind = fsf_pkg::K_HOLLOW;
      fsf_pkg::MODE_DISC:   in_kind = fsf_pkg::K_DISC;
      fsf_pkg::MODE_RING:   in_kind = fsf_pkg::K_RING;
      fsf_pkg::MODE_READ:   in_kind = fsf_pkg::K_READ;
      default:              in_kind = fsf_pkg::K_NOP;
    endcase
  end

  assign in_cmd = '{kind: in_kind, x: pos_x, y: pos_y, w: rect_width,
                    h: rect_height, r: radius, t: thickness};

  assign cmd_ready = (count != 2'd2);
  assign push      = cmd_valid && cmd_ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> count != 2'd0)
    else $error("queue popped while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count beyond depth");
`endif

endmodule

[rtl/fsf_sqrt.sv]
// Iterative floor square root, one result bit per cycle.
module fsf_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fsf_pkg::SQ_W-1:0]   value,
  output logic                       busy,
  output logic                       done,
  output logic [fsf_pkg::RAD_W-1:0]  root
);

  localparam int REM_W = fsf_pkg::RAD_W + 3;
  localparam int CNT_W = $clog2(fsf_pkg::RAD_W);

  logic [fsf_pkg::SQ_W-1:0] val;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic [CNT_W-1:0]         cnt;

  assign rem_sh = {rem[REM_W-3:0], val[fsf_pkg::SQ_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        val  <= value;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(fsf_pkg::RAD_W - 1);
      end else if (busy) begin
        val <= {val[fsf_pkg::SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[fsf_pkg::RAD_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[fsf_pkg::RAD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("root done while still busy");
`endif

endmodule

[rtl/fsf_back.sv]
// Drawing sequencer: walks spans of the frame store by read-modify-write.
module fsf_back #(
  parameter int ROWS          = fsf_pkg::ROWS_DEF,
  parameter int BYTES_PER_ROW = fsf_pkg::BPR_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  fsf_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [7:0]     read_data,
  output logic           done_res
);

  localparam int DEPTH  = ROWS * BYTES_PER_ROW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam fsf_pkg::coord_t ROWS_C = fsf_pkg::coord_t'(ROWS);
  localparam fsf_pkg::coord_t COLS_C =
    fsf_pkg::coord_t'(BYTES_PER_ROW * fsf_pkg::PIX_PER_BYTE);

  fsf_pkg::state_t state, state_next, ret_state;
  fsf_pkg::cmd_t   cmd;

  logic [3:0]        mem [DEPTH];
  logic [3:0]        rdata;
  logic              mem_wen, mem_ren;
  logic [ADDR_W-1:0] mem_addr;
  logic [3:0]        mem_wdata;

  logic [ADDR_W-1:0] clr_addr;
  logic              clr_cmd;
  logic [1:0]        rect_idx;
  logic              rect_last;
  fsf_pkg::coord_t   rx, ry, rw, rh, ry0, ry1;
  fsf_pkg::coord_t   row, row_end;
  fsf_pkg::coord_t   span_y, span_x0, span_x1, x0c, x1c, x0c_r, x1c_r, base;
  fsf_pkg::coord_t   cx, cy, cw, ch, ct, dy;
  logic              span_ok;
  logic              on;
  logic              pass;
  logic [fsf_pkg::RAD_W-1:0] cr, ady;
  logic [fsf_pkg::SQ_W-1:0]  rr, dd;
  logic              sq_start, sq_busy, sq_done;
  logic [fsf_pkg::RAD_W-1:0] sq_root;
  logic [3:0]        mask;
  logic [7:0]        rd_val;
  logic              read_ok;

  fsf_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (rr - dd),
    .busy  (sq_busy),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign cx = fsf_pkg::coord_t'(cmd.x);
  assign cy = fsf_pkg::coord_t'(cmd.y);
  assign cw = fsf_pkg::coord_t'(cmd.w);
  assign ch = fsf_pkg::coord_t'(cmd.h);
  assign ct = fsf_pkg::coord_t'(cmd.t);

  // The four border bands of a hollow rectangle, or the whole filled one.
  always_comb begin
    rx = cx; ry = cy; rw = cw; rh = ch;
    if (cmd.kind == fsf_pkg::K_HOLLOW) begin
      case (rect_idx)
        2'd0: begin rw = ct; end
        2'd1: begin rx = cx + cw - ct; rw = ct; end
        2'd2: begin rh = ct; end
        default: begin ry = cy + ch - ct; rh = ct; end
      endcase
    end
    ry0 = (ry < 0) ? '0 : ry;
    ry1 = (ry + rh > ROWS_C) ? ROWS_C : ry + rh;
  end

  assign rect_last = (cmd.kind != fsf_pkg::K_HOLLOW) || (rect_idx == 2'd3);

  assign x0c     = (span_x0 < 0) ? '0 : span_x0;
  assign x1c     = (span_x1 > COLS_C) ? COLS_C : span_x1;
  assign span_ok = (span_y >= 0) && (span_y < ROWS_C) && (x0c < x1c);
  assign ady     = fsf_pkg::RAD_W'((dy < 0) ? -dy : dy);
  assign read_ok = (int'(cmd.x) < BYTES_PER_ROW) && (int'(cmd.y) < ROWS);

  always_comb begin
    for (int p = 0; p < fsf_pkg::PIX_PER_BYTE; p++) begin
      mask[3-p] = (base + fsf_pkg::coord_t'(p) >= x0c_r) &&
                  (base + fsf_pkg::coord_t'(p) < x1c_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wen) mem[mem_addr] <= mem_wdata;
    if (mem_ren) rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fsf_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    sq_start   = 1'b0;
    mem_wen    = 1'b0;
    mem_ren    = 1'b0;
    mem_addr   = ADDR_W'(int'(span_y) * BYTES_PER_ROW + int'(base >>> 2));
    mem_wdata  = on ? (rdata | mask) : (rdata & ~mask);
    case (state)
      fsf_pkg::S_CLEAR: begin
        mem_wen   = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
        if (clr_addr == ADDR_W'(DEPTH - 1))
          state_next = clr_cmd ? fsf_pkg::S_DONE : fsf_pkg::S_IDLE;
      end
      fsf_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            fsf_pkg::K_CLEAR:  state_next = fsf_pkg::S_CLEAR;
            fsf_pkg::K_FILL,
            fsf_pkg::K_HOLLOW: state_next = fsf_pkg::S_RECT;
            fsf_pkg::K_DISC,
            fsf_pkg::K_RING:   state_next = fsf_pkg::S_DISC_ROW;
            fsf_pkg::K_READ:   state_next = fsf_pkg::S_READ;
            default:           state_next = fsf_pkg::S_DONE;
          endcase
        end
      end
      fsf_pkg::S_RECT: begin
        if (rw <= 0 || rh <= 0 || ry0 >= ry1) begin
          if (rect_last) state_next = fsf_pkg::S_DONE;
        end else begin
          state_next = fsf_pkg::S_RECT_ROW;
        end
      end
      fsf_pkg::S_RECT_ROW: begin
        if (row < row_end)  state_next = fsf_pkg::S_SPAN_START;
        else if (rect_last) state_next = fsf_pkg::S_DONE;
        else                state_next = fsf_pkg::S_RECT;
      end
      fsf_pkg::S_DISC_ROW: begin
        if (dy > fsf_pkg::coord_t'(cr)) begin
          if (!(cmd.kind == fsf_pkg::K_RING && !pass && ct < fsf_pkg::coord_t'(cmd.r)))
            state_next = fsf_pkg::S_DONE;
        end else begin
          state_next = fsf_pkg::S_DISC_MUL;
        end
      end
      fsf_pkg::S_DISC_MUL: state_next = fsf_pkg::S_DISC_SQ;
      fsf_pkg::S_DISC_SQ: begin
        sq_start   = 1'b1;
        state_next = fsf_pkg::S_DISC_WAIT;
      end
      fsf_pkg::S_DISC_WAIT: if (sq_done) state_next = fsf_pkg::S_SPAN_START;
      fsf_pkg::S_DISC_NEXT: state_next = fsf_pkg::S_DISC_ROW;
      fsf_pkg::S_SPAN_START: state_next = span_ok ? fsf_pkg::S_SPAN_RD : ret_state;
      fsf_pkg::S_SPAN_RD: begin
        mem_ren    = 1'b1;
        state_next = fsf_pkg::S_SPAN_WR;
      end
      fsf_pkg::S_SPAN_WR: begin
        mem_wen    = 1'b1;
        state_next = (base + fsf_pkg::coord_t'(4) < x1c_r) ? fsf_pkg::S_SPAN_RD : ret_state;
      end
      fsf_pkg::S_READ: begin
        mem_addr = ADDR_W'(int'(cmd.y) * BYTES_PER_ROW + int'(cmd.x));
        if (read_ok) begin
          mem_ren    = 1'b1;
          state_next = fsf_pkg::S_READ_WAIT;
        end else begin
          state_next = fsf_pkg::S_DONE;
        end
      end
      fsf_pkg::S_READ_WAIT: state_next = fsf_pkg::S_DONE;
      fsf_pkg::S_DONE: if (!res_valid || res_ready) state_next = fsf_pkg::S_IDLE;
      default: state_next = fsf_pkg::S_IDLE;
    endcase
  end

  // Datapath registers, advanced alongside the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_cmd  <= 1'b0;
    end else begin
      case (state)
        fsf_pkg::S_CLEAR: clr_addr <= clr_addr + 1'b1;
        fsf_pkg::S_IDLE: begin
          clr_addr <= '0;
          clr_cmd  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fsf_pkg::S_IDLE: begin
        cmd      <= q_cmd;
        rect_idx <= '0;
        on       <= 1'b1;
        pass     <= 1'b0;
        cr       <= q_cmd.r;
        dy       <= -fsf_pkg::coord_t'(q_cmd.r);
        rd_val   <= '0;
      end
      fsf_pkg::S_RECT: begin
        row     <= ry0;
        row_end <= ry1;
        span_x0 <= rx;
        span_x1 <= rx + rw;
        if (rw <= 0 || rh <= 0 || ry0 >= ry1) rect_idx <= rect_idx + 1'b1;
      end
      fsf_pkg::S_RECT_ROW: begin
        if (row < row_end) begin
          span_y    <= row;
          row       <= row + fsf_pkg::coord_t'(1);
          ret_state <= fsf_pkg::S_RECT_ROW;
        end else begin
          rect_idx <= rect_idx + 1'b1;
        end
      end
      fsf_pkg::S_DISC_ROW: begin
        if (dy > fsf_pkg::coord_t'(cr)) begin
          // Second pass of a ring clears the inner disc.
          cr   <= fsf_pkg::RAD_W'(cmd.r - cmd.t);
          dy   <= -(fsf_pkg::coord_t'(cmd.r) - ct);
          on   <= 1'b0;
          pass <= 1'b1;
        end
      end
      fsf_pkg::S_DISC_MUL: begin
        rr <= cr * cr;
        dd <= ady * ady;
      end
      fsf_pkg::S_DISC_WAIT: begin
        span_y    <= cy + dy;
        span_x0   <= cx - fsf_pkg::coord_t'(sq_root);
        span_x1   <= cx + fsf_pkg::coord_t'(sq_root);
        ret_state <= fsf_pkg::S_DISC_NEXT;
      end
      fsf_pkg::S_DISC_NEXT: dy <= dy + fsf_pkg::coord_t'(1);
      fsf_pkg::S_SPAN_START: begin
        x0c_r <= x0c;
        x1c_r <= x1c;
        base  <= x0c & ~fsf_pkg::coord_t'(3);
      end
      fsf_pkg::S_SPAN_WR: base <= base + fsf_pkg::coord_t'(4);
      fsf_pkg::S_READ_WAIT: rd_val <= {rdata, 4'b0000};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (state == fsf_pkg::S_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
        read_data <= rd_val;
        done_res  <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst) mem_wen |-> !mem_ren)
    else $error("store read and written in one cycle");
  a_span_in_range: assert property (@(posedge clk) disable iff (rst)
      state == fsf_pkg::S_SPAN_WR |-> base < x1c_r && x0c_r < x1c_r)
    else $error("span byte outside its clipped range");
  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst) sq_start |-> !sq_busy)
    else $error("root started while busy");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
      q_pop |=> state != fsf_pkg::S_IDLE)
    else $error("command taken but sequencer stayed idle");
`endif

endmodule

[tb/framebuffer_shape_fill_checker.sv]
// Checker for the frame store drawing engine: shadow store, prediction and comparison.
`timescale 1ns / 1ps
module framebuffer_shape_fill_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_ready,
  input  logic [2:0] mode,
  input  logic [9:0] pos_x,
  input  logic [9:0] pos_y,
  input  logic [9:0] rect_width,
  input  logic [9:0] rect_height,
  input  logic [8:0] radius,
  input  logic [9:0] thickness,
  input  logic       res_valid,
  input  logic       res_ready,
  input  logic [7:0] read_data,
  input  logic       done_res,
  output int         fail_count,
  output int         pending,
  output int         words_checked
);

  localparam int NROWS = fsf_pkg::ROWS_DEF;
  localparam int NBPR  = fsf_pkg::BPR_DEF;
  localparam int PPB   = fsf_pkg::PIX_PER_BYTE;
  localparam int NCOLS = NBPR * PPB;

  logic [3:0] shadow [NROWS*NBPR];
  logic [7:0] expected_bytes [$];

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int floor_sqrt(input int v);
    int s;
    s = 0;
    while ((s + 1) * (s + 1) <= v) s++;
    return s;
  endfunction

  function automatic void paint_span(input int y, input int x0, input int x1, input bit on);
    int c;
    int idx;
    if (y < 0 || y >= NROWS) return;
    if (x0 < 0) x0 = 0;
    if (x1 > NCOLS) x1 = NCOLS;
    for (c = x0; c < x1; c++) begin
      idx = y * NBPR + c / PPB;
      if (on) shadow[idx][3 - c % PPB] = 1'b1;
      else shadow[idx][3 - c % PPB] = 1'b0;
    end
  endfunction

  function automatic void paint_rect(input int x, input int y, input int w, input int h);
    int r;
    if (w <= 0 || h <= 0) return;
    for (r = y; r < y + h; r++) paint_span(r, x, x + w, 1'b1);
  endfunction

  function automatic void paint_disc(input int cx, input int cy, input int r, input bit on);
    int dy;
    int s;
    for (dy = -r; dy <= r; dy++) begin
      s = floor_sqrt(r * r - dy * dy);
      paint_span(cy + dy, cx - s, cx + s, on);
    end
  endfunction

  function automatic logic [7:0] draw_command(input logic [2:0] m, input int x, input int y,
      input int w, input int h, input int r, input int t);
    logic [7:0] rd;
    rd = 8'h00;
    case (m)
      fsf_pkg::MODE_CLEAR: begin
        foreach (shadow[i]) shadow[i] = 4'h0;
      end
      fsf_pkg::MODE_FILL: paint_rect(x, y, w, h);
      fsf_pkg::MODE_HOLLOW: begin
        paint_rect(x, y, t, h);
        paint_rect(x + w - t, y, t, h);
        paint_rect(x, y, w, t);
        paint_rect(x, y + h - t, w, t);
      end
      fsf_pkg::MODE_DISC: paint_disc(x, y, r, 1'b1);
      fsf_pkg::MODE_RING: begin
        paint_disc(x, y, r, 1'b1);
        if (t < r) paint_disc(x, y, r - t, 1'b0);
      end
      fsf_pkg::MODE_READ: begin
        if (x < NBPR && y < NROWS) rd = {shadow[y * NBPR + x], 4'h0};
      end
      default: ;
    endcase
    return rd;
  endfunction

  initial begin
    fail_count = 0;
    words_checked = 0;
    pending = 0;
    foreach (shadow[i]) shadow[i] = 4'h0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        words_checked++;
        if (expected_bytes.size() == 0) begin
          report("unexpected result word", read_data, 0);
        end else begin
          if (read_data !== expected_bytes[0])
            report("read_data", read_data, expected_bytes[0]);
          if (done_res !== 1'b1) report("done_res", done_res, 1);
          void'(expected_bytes.pop_front());
        end
      end
      if (cmd_valid && cmd_ready)
        expected_bytes.push_back(draw_command(mode, pos_x, pos_y, rect_width, rect_height,
                                              radius, thickness));
      pending = expected_bytes.size();
    end
  end
endmodule

[tb/framebuffer_shape_fill_test.sv]
// Top of the drawing engine testbench: stimulus, handshakes and the verdict.
`timescale 1ns / 1ps
module framebuffer_shape_fill_test;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_ready;
  logic [2:0] mode = '0;
  logic [9:0] pos_x = '0, pos_y = '0, rect_width = '0, rect_height = '0, thickness = '0;
  logic [8:0] radius = '0;
  logic       res_valid;
  logic       res_ready = 1'b0;
  logic [7:0] read_data;
  logic       done_res;
  int         fail_count, pending, words_checked;
  bit         calm = 1'b0;
  int         sent = 0;

  always #5 clk = ~clk;

  framebuffer_shape_fill dut (.*);
  framebuffer_shape_fill_checker chk (.*);

  // Receiver stalls in bursts until the closing stretch.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 16);
        res_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_word(input logic [2:0] m, input int x, input int y, input int w,
      input int h, input int r, input int t);
    if (!calm && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    mode <= m; pos_x <= 10'(x); pos_y <= 10'(y); rect_width <= 10'(w);
    rect_height <= 10'(h); radius <= 9'(r); thickness <= 10'(t);
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent++;
  endtask

  // Mostly small shapes near the store so the drawing stays fast but the bits still toggle.
  task automatic random_word();
    logic [2:0] m;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 2) m = fsf_pkg::MODE_CLEAR;
    else if (pick < 40) m = fsf_pkg::MODE_READ;
    else if (pick < 98) m = 3'($urandom_range(1, 4));
    else m = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 19) == 0)
      send_word(m, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 511), $urandom_range(0, 1023));
    else if (m == fsf_pkg::MODE_READ)
      send_word(m, $urandom_range(0, 33), $urandom_range(0, 130), $urandom, $urandom,
                $urandom, $urandom);
    else
      send_word(m, $urandom_range(0, 140), $urandom_range(0, 140), $urandom_range(0, 40),
                $urandom_range(0, 40), $urandom_range(0, 24), $urandom_range(0, 30));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Directed: field extremes, each mode, clipping, thick borders and rings, bad modes.
    send_word(fsf_pkg::MODE_READ, 0, 0, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_FILL, 0, 0, 1023, 1023, 511, 1023);
    send_word(fsf_pkg::MODE_READ, 31, 127, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_READ, 1023, 1023, 1023, 1023, 511, 1023);
    send_word(fsf_pkg::MODE_CLEAR, 1023, 1023, 1023, 1023, 511, 1023);
    send_word(fsf_pkg::MODE_FILL, 5, 7, 0, 9, 0, 0);
    send_word(fsf_pkg::MODE_FILL, 3, 2, 9, 3, 0, 0);
    send_word(fsf_pkg::MODE_READ, 0, 2, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_READ, 1, 3, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_HOLLOW, 10, 10, 20, 12, 0, 2);
    send_word(fsf_pkg::MODE_HOLLOW, 120, 120, 30, 30, 0, 40);
    send_word(fsf_pkg::MODE_READ, 31, 125, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_DISC, 64, 64, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_DISC, 126, 2, 0, 0, 9, 0);
    send_word(fsf_pkg::MODE_RING, 40, 90, 0, 0, 12, 3);
    send_word(fsf_pkg::MODE_RING, 80, 30, 0, 0, 6, 6);
    send_word(fsf_pkg::MODE_READ, 10, 90, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_READ, 20, 30, 0, 0, 0, 0);
    send_word(3'd6, 1, 1, 1, 1, 1, 1);
    send_word(3'd7, 0, 0, 0, 0, 0, 0);
    send_word(fsf_pkg::MODE_READ, 32, 128, 0, 0, 0, 0);
    // Hold the sender off until the engine has drained.
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (1000) random_word();
    calm = 1'b1;
    repeat (40) random_word();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d command words, checked %0d result words across all modes,", sent,
             words_checked);
    $display("with clipping, thick borders and rings, stalls on both channels.");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #400ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
